FILE: rtl/bba_pkg.sv
// Buddy block allocator package: slot header layout, state codes, status codes
// and the size-to-order helper. No dependencies.
package bba_pkg;

  localparam int unsigned SLOT_W    = 12;   // 4096 slots of 16 bytes
  localparam int unsigned NSLOTS    = 4096;
  localparam int unsigned LINK_W    = 13;   // valid bit over a slot index
  localparam int unsigned ORD_W     = 4;
  localparam int unsigned PAGES_W   = 5;
  localparam logic [ORD_W-1:0] TOP_ORDER  = 4'd10;
  localparam logic [ORD_W-1:0] PAGE_ORDER = 4'd8;   // one page is order 8
  localparam logic [PAGES_W-1:0] HEAP_PAGES = 5'd16;
  localparam logic [32:0] MAX_BLOCK_BYTES = 33'd16384;
  localparam logic [32:0] HEADER_BYTES    = 33'd16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OOM       = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_DOUBLE    = 3'd4;

  // One header word per slot
  typedef struct packed {
    logic              is_hdr;
    logic [ORD_W-1:0]  order;
    logic              free;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } hdr_t;

  typedef struct packed {
    logic [15:0]      data_offset;
    logic [ORD_W-1:0] block_order;
    logic [2:0]       status;
  } res_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FREE_CHK, S_SEARCH, S_GROW, S_SPLIT,
    S_MERGE, S_MERGE_CHK, S_MERGE_U2, S_MERGE_FIX,
    P_WR, P_NB, U_RD, U_GET, U_P, U_N0, U_N, S_RESP
  } state_e;

  // Smallest order whose block covers total bytes (total in 16..16384)
  function automatic logic [ORD_W-1:0] order_of(input logic [14:0] total);
    logic [13:0] t;
    logic [3:0]  len;
    t   = 14'(total - 15'd1);
    len = 4'd0;
    for (int i = 0; i < 14; i++) begin
      if (t[i]) len = 4'(i + 1);
    end
    return (len > 4'd4) ? 4'(len - 4'd4) : 4'd0;
  endfunction

endpackage

FILE: rtl/bba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bba_seq.sv
// Allocator sequencer: free-list heads, heap end and the header memory walk.
// Depends on bba_pkg and bba_ram.
module bba_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         opcode_i,
  input  logic [31:0]                  request_bytes_i,
  input  logic [15:0]                  pointer_offset_i,
  input  logic [bba_pkg::PAGES_W-1:0]  limit_i,
  output logic                         idle_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output bba_pkg::res_t                res_o
);
  import bba_pkg::*;

  state_e state_q, state_d, ret_q, ret_d;
  logic [SLOT_W-1:0]  s_q, s_d, x_q, x_d, bs_q, bs_d, clr_q, clr_d;
  logic [ORD_W-1:0]   o_q, o_d, c_q, c_d, xo_q, xo_d;
  logic [LINK_W-1:0]  lnk_q, lnk_d, p_q, p_d, n_q, n_d;
  logic [2:0]         st_q, st_d;
  logic               op_q, op_d;
  logic [PAGES_W-1:0] end_q, end_d;
  logic [LINK_W-1:0]  head_q [11];

  // head write port and single read port
  logic               hw_en;
  logic [ORD_W-1:0]   hw_idx, hidx;
  logic [LINK_W-1:0]  hw_val, hrd;

  // memory port
  logic              we;
  logic [SLOT_W-1:0] waddr, raddr;
  hdr_t              wdata, rdata;

  // scratch
  logic [32:0]        total;
  logic [15:0]        boff;
  logic [ORD_W-1:0]   g, cn, onew;
  logic [2:0]         pages;
  logic [PAGES_W-1:0] lim;
  logic [5:0]         grown;
  logic [LINK_W-1:0]  b;
  logic [SLOT_W-1:0]  bsn;

  bba_ram #(.WIDTH($bits(hdr_t)), .DEPTH(NSLOTS)) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign hidx = (state_q == S_SEARCH) ? c_q : xo_q;
  assign hrd  = head_q[hidx];

  // State and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_IDLE;
      clr_q   <= '0;
      end_q   <= 5'd1;
      st_q    <= ST_OK;
      op_q    <= OP_ALLOC;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      clr_q   <= clr_d;
      end_q   <= end_d;
      st_q    <= st_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    x_q   <= x_d;
    bs_q  <= bs_d;
    o_q   <= o_d;
    c_q   <= c_d;
    xo_q  <= xo_d;
    lnk_q <= lnk_d;
    p_q   <= p_d;
    n_q   <= n_d;
  end

  // Free-list heads: one-page block at slot zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 11; i++) begin
        head_q[i] <= (4'(i) == PAGE_ORDER) ? {1'b1, {SLOT_W{1'b0}}} : '0;
      end
    end else if (hw_en) begin
      head_q[hw_idx] <= hw_val;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    clr_d   = clr_q;
    end_d   = end_q;
    st_d    = st_q;
    op_d    = op_q;
    s_d     = s_q;
    x_d     = x_q;
    bs_d    = bs_q;
    o_d     = o_q;
    c_d     = c_q;
    xo_d    = xo_q;
    lnk_d   = lnk_q;
    p_d     = p_q;
    n_d     = n_q;
    hw_en   = 1'b0;
    hw_idx  = xo_q;
    hw_val  = '0;
    we      = 1'b0;
    waddr   = x_q;
    wdata   = '0;
    raddr   = x_q;
    total   = {1'b0, request_bytes_i} + HEADER_BYTES;
    boff    = pointer_offset_i - 16'd16;
    g       = (o_q < PAGE_ORDER) ? PAGE_ORDER : o_q;
    pages   = 3'(3'd1 << (g - PAGE_ORDER));
    lim     = (limit_i > HEAP_PAGES) ? HEAP_PAGES : limit_i;
    grown   = {1'b0, end_q} + {3'b0, pages};
    cn      = c_q - 4'd1;
    b       = {1'b0, s_q} + (13'd1 << cn);
    bsn     = s_q ^ (12'd1 << o_q);
    onew    = (rdata.order > TOP_ORDER) ? TOP_ORDER : rdata.order;

    unique case (state_q)
      // wipe headers after reset, seed slot zero as the first page block
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        if (clr_q == '0) begin
          wdata.is_hdr = 1'b1;
          wdata.order  = PAGE_ORDER;
          wdata.free   = 1'b1;
        end
        clr_d = clr_q + 12'd1;
        if (clr_q == 12'(NSLOTS - 1)) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (start_i) begin
          op_d = opcode_i;
          st_d = ST_OK;
          if (opcode_i == OP_ALLOC) begin
            if (total > MAX_BLOCK_BYTES) begin
              st_d    = ST_TOO_LARGE;
              state_d = S_RESP;
            end else begin
              o_d     = order_of(total[14:0]);
              c_d     = order_of(total[14:0]);
              state_d = S_SEARCH;
            end
          end else begin
            raddr = boff[15:4];
            s_d   = boff[15:4];
            if (pointer_offset_i < 16'd16 || boff[3:0] != 4'd0 ||
                {1'b0, boff[15:12]} >= end_q) begin
              st_d    = ST_INVALID;
              state_d = S_RESP;
            end else begin
              state_d = S_FREE_CHK;
            end
          end
        end
      end

      // header of the block to free is on the read port
      S_FREE_CHK: begin
        if (!rdata.is_hdr) begin
          st_d    = ST_INVALID;
          state_d = S_RESP;
        end else if (rdata.free) begin
          st_d    = ST_DOUBLE;
          state_d = S_RESP;
        end else begin
          o_d     = onew;
          x_d     = s_q;
          xo_d    = onew;
          ret_d   = S_MERGE;
          state_d = P_WR;
        end
      end

      // one order a cycle upward
      S_SEARCH: begin
        if (hrd[LINK_W-1]) begin
          s_d     = hrd[SLOT_W-1:0];
          x_d     = hrd[SLOT_W-1:0];
          xo_d    = c_q;
          ret_d   = S_SPLIT;
          state_d = U_RD;
        end else if (c_q == TOP_ORDER) begin
          state_d = S_GROW;
        end else begin
          c_d = c_q + 4'd1;
        end
      end

      // new block at the old heap end; all lists from o upward are empty
      S_GROW: begin
        if (grown > {1'b0, lim}) begin
          st_d    = ST_OOM;
          state_d = S_RESP;
        end else begin
          we           = 1'b1;
          waddr        = {end_q[3:0], 8'd0};
          wdata.is_hdr = 1'b1;
          wdata.order  = g;
          wdata.free   = 1'b1;
          hw_en        = 1'b1;
          hw_idx       = g;
          hw_val       = {1'b1, end_q[3:0], 8'd0};
          end_d        = 5'(grown);
          c_d          = g;
          state_d      = S_SEARCH;
        end
      end

      // push upper halves until the target order is reached
      S_SPLIT: begin
        if (c_q > o_q) begin
          c_d = cn;
          if (!b[LINK_W-1]) begin
            x_d     = b[SLOT_W-1:0];
            xo_d    = cn;
            ret_d   = S_SPLIT;
            state_d = P_WR;
          end
        end else begin
          we           = 1'b1;
          waddr        = s_q;
          wdata.is_hdr = 1'b1;
          wdata.order  = o_q;
          st_d         = ST_OK;
          state_d      = S_RESP;
        end
      end

      // look at the buddy of equal size
      S_MERGE: begin
        raddr = bsn;
        bs_d  = bsn;
        if (o_q == TOP_ORDER || {1'b0, bsn} >= {end_q, 8'd0}) begin
          state_d = S_RESP;
        end else begin
          state_d = S_MERGE_CHK;
        end
      end

      S_MERGE_CHK: begin
        if (!rdata.is_hdr || !rdata.free || rdata.order != o_q) begin
          state_d = S_RESP;
        end else begin
          x_d     = s_q;
          xo_d    = o_q;
          ret_d   = S_MERGE_U2;
          state_d = U_RD;
        end
      end

      S_MERGE_U2: begin
        x_d     = bs_q;
        xo_d    = o_q;
        ret_d   = S_MERGE_FIX;
        state_d = U_RD;
      end

      // drop the upper header, push the merged block
      S_MERGE_FIX: begin
        we      = 1'b1;
        waddr   = (bs_q < s_q) ? s_q : bs_q;
        s_d     = (bs_q < s_q) ? bs_q : s_q;
        x_d     = (bs_q < s_q) ? bs_q : s_q;
        o_d     = o_q + 4'd1;
        xo_d    = o_q + 4'd1;
        ret_d   = S_MERGE;
        state_d = P_WR;
      end

      // push x on list xo
      P_WR: begin
        we           = 1'b1;
        waddr        = x_q;
        wdata.is_hdr = 1'b1;
        wdata.order  = xo_q;
        wdata.free   = 1'b1;
        wdata.next   = hrd;
        hw_en        = 1'b1;
        hw_val       = {1'b1, x_q};
        lnk_d        = hrd;
        raddr        = hrd[SLOT_W-1:0];
        state_d      = hrd[LINK_W-1] ? P_NB : ret_q;
      end

      P_NB: begin
        we         = 1'b1;
        waddr      = lnk_q[SLOT_W-1:0];
        wdata      = rdata;
        wdata.prev = {1'b1, x_q};
        state_d    = ret_q;
      end

      // unlink x from list xo
      U_RD: begin
        raddr   = x_q;
        state_d = U_GET;
      end

      U_GET: begin
        p_d          = rdata.prev;
        n_d          = rdata.next;
        we           = 1'b1;
        waddr        = x_q;
        wdata.is_hdr = rdata.is_hdr;
        wdata.order  = rdata.order;
        raddr        = rdata.prev[SLOT_W-1:0];
        if (rdata.prev[LINK_W-1]) begin
          state_d = U_P;
        end else begin
          hw_en   = 1'b1;
          hw_val  = rdata.next;
          state_d = U_N0;
        end
      end

      U_P: begin
        we         = 1'b1;
        waddr      = p_q[SLOT_W-1:0];
        wdata      = rdata;
        wdata.next = n_q;
        state_d    = U_N0;
      end

      U_N0: begin
        raddr   = n_q[SLOT_W-1:0];
        state_d = n_q[LINK_W-1] ? U_N : ret_q;
      end

      U_N: begin
        we         = 1'b1;
        waddr      = n_q[SLOT_W-1:0];
        wdata      = rdata;
        wdata.prev = p_q;
        state_d    = ret_q;
      end

      S_RESP: begin
        if (res_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Result fields
  always_comb begin
    res_o = '0;
    res_o.status = st_q;
    if (st_q == ST_OK) begin
      res_o.block_order = o_q;
      if (op_q == OP_ALLOC) res_o.data_offset = {s_q, 4'd0} + 16'd16;
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);

endmodule

FILE: rtl/buddy_block_allocator.sv
// Buddy block allocator top level: APB limit register, input handshake and
// output register. Depends on bba_pkg and bba_seq.
//
// Usage: an item on the in channel (opcode, request_bytes, pointer_offset)
// is an allocate (opcode 0) or a free (opcode 1). Each item gives exactly one
// transaction on the out channel (data_offset, block_order, status).
// Items are handled one at a time: in_ready_o is high while the sequencer is
// idle. An item walks the header memory one access per cycle, with read data
// registered in the RAM: an immediate reject goes straight to the result, a
// typical allocate searches up to eleven list heads, then does one unlink
// and one push per split order, and a free may merge through all ten orders
// (two unlinks and one push per merge step).
// The result sits in an output register; the next item is taken while it
// waits, and a stalled receiver holds the sequencer only once it has a second
// result ready.
// After reset the sequencer sweeps all 4096 header slots with in_ready_o low;
// APB writes to heap_limit_pages are accepted meanwhile.
module buddy_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] request_bytes_i,
  input  logic [15:0] pointer_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] data_offset_o,
  output logic [3:0]  block_order_o,
  output logic [2:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bba_pkg::*;

  logic [PAGES_W-1:0] limit_q;
  logic               idle, res_valid, res_ready, out_valid_q;
  res_t               res, out_q;

  // heap_limit_pages register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 5'd16;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      limit_q <= pwdata[PAGES_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {27'd0, limit_q};

  assign in_ready_o = idle;

  bba_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (in_valid_i && idle),
    .opcode_i        (opcode_i),
    .request_bytes_i (request_bytes_i),
    .pointer_offset_i(pointer_offset_i),
    .limit_i         (limit_q),
    .idle_o          (idle),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // Output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign out_valid_o   = out_valid_q;
  assign data_offset_o = out_q.data_offset;
  assign block_order_o = out_q.block_order;
  assign status_o      = out_q.status;

endmodule

FILE: dv/buddy_block_allocator_tb.sv
// Self-checking testbench for buddy_block_allocator: directed and random
// alloc/free traffic with a built-in heap predictor. Depends on bba_pkg and buddy_block_allocator.
module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam logic [2:0] ADDR_HEAP_LIMIT = 3'd0;
  localparam int unsigned CYCLE_LIMIT    = 3000000;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned PHASE_ITEMS    = 250;
  localparam int unsigned NUM_ROWS       = 18;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        opcode_i;
  logic [31:0] request_bytes_i;
  logic [15:0] pointer_offset_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] data_offset_o;
  logic [3:0]  block_order_o;
  logic [2:0]  status_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  buddy_block_allocator i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .request_bytes_i,
    .pointer_offset_i, .out_valid_o, .out_ready_i, .data_offset_o,
    .block_order_o, .status_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  // Heap model state
  logic [3:0]   blk_order [NSLOTS];
  logic         blk_free  [NSLOTS];
  logic [12:0]  blk_next  [NSLOTS];
  logic [12:0]  blk_prev  [NSLOTS];
  logic         slot_live [NSLOTS];
  logic [12:0]  free_head [11];
  int unsigned  heap_pages;
  int unsigned  limit_pages;

  res_t          result_q [$];
  logic [15:0]   live_ptrs [$];
  logic [15:0]   freed_ptrs [$];
  int unsigned   errors;
  int unsigned   cycles;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  bit            hold_req;

  typedef struct {
    logic        op;
    logic [31:0] req;
    logic [15:0] ptr;
    bit          typed;
    res_t        want;
  } dir_row_t;

  // Directed rows; typed expectations only where obvious
  dir_row_t dir_rows [NUM_ROWS] = '{
    '{OP_ALLOC, 32'd0,          16'd0,     1'b1, '{16'd16, 4'd0, ST_OK}},
    '{OP_ALLOC, 32'hFFFF_FFFF,  16'hFFFF,  1'b1, '{16'd0, 4'd0, ST_TOO_LARGE}},
    '{OP_ALLOC, 32'd16369,      16'd0,     1'b1, '{16'd0, 4'd0, ST_TOO_LARGE}},
    '{OP_ALLOC, 32'd16368,      16'd0,     1'b0, '{16'd0, 4'd0, ST_OK}},
    '{OP_FREE,  32'hFFFF_FFFF,  16'd0,     1'b1, '{16'd0, 4'd0, ST_INVALID}},
    '{OP_FREE,  32'd0,          16'hFFFF,  1'b1, '{16'd0, 4'd0, ST_INVALID}},
    '{OP_FREE,  32'd0,          16'd17,    1'b1, '{16'd0, 4'd0, ST_INVALID}},
    '{OP_FREE,  32'd0,          16'd8,     1'b1, '{16'd0, 4'd0, ST_INVALID}},
    '{OP_FREE,  32'd0,          16'd16,    1'b0, '{16'd0, 4'd0, ST_OK}},
    '{OP_FREE,  32'd0,          16'd16,    1'b1, '{16'd0, 4'd0, ST_DOUBLE}},
    '{OP_ALLOC, 32'd4080,       16'd0,     1'b0, '{16'd0, 4'd0, ST_OK}},
    '{OP_ALLOC, 32'd1,          16'd0,     1'b0, '{16'd0, 4'd0, ST_OK}},
    '{OP_FREE,  32'd0,          16'd4112,  1'b0, '{16'd0, 4'd0, ST_OK}},
    '{OP_FREE,  32'd0,          16'd4112,  1'b0, '{16'd0, 4'd0, ST_OK}},
    '{OP_FREE,  32'd0,          16'd32,    1'b0, '{16'd0, 4'd0, ST_OK}},
    '{OP_ALLOC, 32'h7FFF_FFFF,  16'd0,     1'b1, '{16'd0, 4'd0, ST_TOO_LARGE}},
    '{OP_ALLOC, 32'd0,          16'd0,     1'b0, '{16'd0, 4'd0, ST_OK}},
    '{OP_FREE,  32'd0,          16'd65535, 1'b1, '{16'd0, 4'd0, ST_INVALID}}
  };

  // Free-list helpers
  function automatic void list_push(int unsigned s, int unsigned o);
    logic [12:0] h;
    h = free_head[o];
    blk_free[s] = 1'b1;
    blk_next[s] = h;
    blk_prev[s] = '0;
    if (h[12]) blk_prev[h[11:0]] = {1'b1, 12'(s)};
    free_head[o] = {1'b1, 12'(s)};
  endfunction

  function automatic void list_unlink(int unsigned s, int unsigned o);
    logic [12:0] p, n;
    p = blk_prev[s];
    n = blk_next[s];
    if (p[12]) blk_next[p[11:0]] = n;
    else free_head[o] = n;
    if (n[12]) blk_prev[n[11:0]] = p;
    blk_free[s] = 1'b0;
    blk_next[s] = '0;
    blk_prev[s] = '0;
  endfunction

  function automatic int unsigned size_order(longint unsigned bytes);
    int unsigned o;
    longint unsigned sz;
    o  = 0;
    sz = 16;
    while (sz < bytes && o < 10) begin
      sz = sz << 1;
      o++;
    end
    return o;
  endfunction

  function automatic int unsigned first_nonempty(int unsigned o);
    while (o <= 10 && !free_head[o][12]) o++;
    return o;
  endfunction

  function automatic bit heap_grow(longint unsigned bsize);
    longint unsigned pages;
    int unsigned lim, s;
    pages = (bsize + 4095) / 4096;
    lim   = (limit_pages < 16) ? limit_pages : 16;
    if (heap_pages + pages > lim) return 1'b0;
    s = heap_pages * 256;
    if (s >= NSLOTS) return 1'b0;
    slot_live[s] = 1'b1;
    blk_order[s] = 4'(size_order(pages * 4096));
    list_push(s, blk_order[s]);
    heap_pages += int'(pages);
    return 1'b1;
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < NSLOTS; i++) begin
      blk_order[i] = '0;
      blk_free[i]  = 1'b0;
      blk_next[i]  = '0;
      blk_prev[i]  = '0;
      slot_live[i] = 1'b0;
    end
    for (int i = 0; i <= 10; i++) free_head[i] = '0;
    heap_pages  = 0;
    limit_pages = 16;
    void'(heap_grow(4096));
  endfunction

  // Predict the answer to one transaction and update the heap state
  function automatic res_t heap_step(logic op, logic [31:0] req, logic [15:0] ptr);
    res_t r;
    longint unsigned total, boff, bo, end_bytes;
    int unsigned o, c, s, b, bs;
    r = '{16'd0, 4'd0, ST_OK};
    end_bytes = longint'(heap_pages) * 4096;
    if (op == OP_ALLOC) begin
      total = longint'(req) + 16;
      if (total > 16384) begin
        r.status = ST_TOO_LARGE;
        return r;
      end
      o = size_order(total);
      c = first_nonempty(o);
      if (c > 10) begin
        if (!heap_grow(longint'(16) << o)) begin
          r.status = ST_OOM;
          return r;
        end
        c = first_nonempty(o);
        if (c > 10) begin
          r.status = ST_OOM;
          return r;
        end
      end
      s = free_head[c][11:0];
      list_unlink(s, c);
      // split down, upper halves go back on the lists
      while (c > o) begin
        c--;
        b = s + (1 << c);
        if (b < NSLOTS) begin
          slot_live[b] = 1'b1;
          blk_order[b] = 4'(c);
          list_push(b, c);
        end
      end
      blk_order[s] = 4'(o);
      blk_free[s]  = 1'b0;
      r.data_offset = 16'(s * 16 + 16);
      r.block_order = 4'(o);
      return r;
    end
    if (ptr < 16) begin
      r.status = ST_INVALID;
      return r;
    end
    boff = ptr - 16;
    if (boff % 16 != 0 || boff >= end_bytes || boff / 16 >= NSLOTS) begin
      r.status = ST_INVALID;
      return r;
    end
    s = int'(boff / 16);
    if (!slot_live[s]) begin
      r.status = ST_INVALID;
      return r;
    end
    if (blk_free[s]) begin
      r.status = ST_DOUBLE;
      return r;
    end
    o = (blk_order[s] > 10) ? 10 : blk_order[s];
    list_push(s, o);
    // merge with equal free buddies
    while (o < 10) begin
      bo = (longint'(s) * 16) ^ (longint'(16) << o);
      if (bo >= end_bytes || bo % 16 != 0 || bo / 16 >= NSLOTS) break;
      bs = int'(bo / 16);
      if (!slot_live[bs] || !blk_free[bs] || blk_order[bs] != o) break;
      list_unlink(s, o);
      list_unlink(bs, o);
      if (bs < s) begin
        slot_live[s] = 1'b0;
        s = bs;
      end else begin
        slot_live[bs] = 1'b0;
      end
      o++;
      blk_order[s] = 4'(o);
      list_push(s, o);
    end
    r.block_order = 4'(o);
    return r;
  endfunction

  // Track handed-out pointers so most frees are well formed
  function automatic void track(logic op, logic [15:0] ptr, res_t r);
    if (r.status != ST_OK) return;
    if (op == OP_ALLOC) begin
      if (r.data_offset != 0) live_ptrs.push_back(r.data_offset);
    end else begin
      foreach (live_ptrs[i]) begin
        if (live_ptrs[i] == ptr) begin
          live_ptrs.delete(i);
          break;
        end
      end
      freed_ptrs.push_back(ptr);
      if (freed_ptrs.size() > 16) void'(freed_ptrs.pop_front());
    end
  endfunction

  function automatic logic [31:0] rand_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 240);
    if (r < 85) return $urandom_range(0, 4080);
    if (r < 95) return $urandom_range(0, 16368);
    return $urandom;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("buddy_block_allocator_tb: errors");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold == 0) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        report("extra result transaction", 1, 0);
      end else begin
        want = result_q.pop_front();
        if (data_offset_o !== want.data_offset)
          report("data_offset", data_offset_o, want.data_offset);
        if (block_order_o !== want.block_order)
          report("block_order", block_order_o, want.block_order);
        if (status_o !== want.status)
          report("status", status_o, want.status);
      end
    end
  end

  task automatic apb_write(logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_HEAP_LIMIT;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    limit_pages = value & 32'd31;
  endtask

  // Offer n transactions; directed rows instead of random ones when asked
  task automatic send_items(int unsigned n, bit directed);
    int unsigned issued, taken, r;
    logic        nxt_valid, nxt_op;
    logic [31:0] nxt_req;
    logic [15:0] nxt_ptr;
    res_t        pred;
    issued = 0;
    taken  = 0;
    while (taken < n) begin
      @(posedge clk_i);
      nxt_valid = in_valid_i;
      nxt_op    = opcode_i;
      nxt_req   = request_bytes_i;
      nxt_ptr   = pointer_offset_i;
      if (in_valid_i && in_ready_o) begin
        pred = heap_step(opcode_i, request_bytes_i, pointer_offset_i);
        track(opcode_i, pointer_offset_i, pred);
        if (directed && dir_rows[taken].typed) result_q.push_back(dir_rows[taken].want);
        else result_q.push_back(pred);
        taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && issued < n && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_req   = $urandom;
        nxt_ptr   = 16'($urandom);
        if (directed) begin
          nxt_op  = dir_rows[issued].op;
          nxt_req = dir_rows[issued].req;
          nxt_ptr = dir_rows[issued].ptr;
        end else begin
          r = $urandom_range(0, 99);
          if (live_ptrs.size() > 40) r = 50;
          if (r < 45 || (r < 85 && live_ptrs.size() == 0)) begin
            nxt_op  = OP_ALLOC;
            nxt_req = rand_size();
          end else if (r < 85) begin
            nxt_op  = OP_FREE;
            nxt_ptr = live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
          end else if (r < 93) begin
            nxt_op = OP_FREE;
            if (r < 89) nxt_ptr = 16'($urandom_range(0, 4095) * 16 + 16);
          end else begin
            nxt_op = OP_FREE;
            if (freed_ptrs.size() > 0)
              nxt_ptr = freed_ptrs[$urandom_range(0, freed_ptrs.size() - 1)];
          end
        end
        issued++;
      end
      in_valid_i       <= nxt_valid;
      opcode_i         <= nxt_op;
      request_bytes_i  <= nxt_req;
      pointer_offset_i <= nxt_ptr;
    end
    @(posedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Main sequence
  initial begin
    int unsigned send_pct [NUM_PHASES];
    int unsigned recv_pct [NUM_PHASES];
    logic [31:0] limits   [NUM_PHASES];
    send_pct         = '{0, 56, 0, 25, 0, 0};
    recv_pct         = '{0, 0, 56, 25, 0, 0};
    limits           = '{16, 4, 1, 31, 16, 8};
    errors           = 0;
    cycles           = 0;
    hold_req         = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    opcode_i         = OP_ALLOC;
    request_bytes_i  = '0;
    pointer_offset_i = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    heap_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_items(NUM_ROWS, 1'b1);
    drain();
    for (int p = 0; p < NUM_PHASES; p++) begin
      apb_write(limits[p]);
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      if (p == 4) hold_req = 1'b1;
      send_items(PHASE_ITEMS, 1'b0);
      drain();
    end

    if (errors == 0) begin
      $display("buddy_block_allocator_tb: clean");
    end else begin
      $display("buddy_block_allocator_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_seq.sv
rtl/buddy_block_allocator.sv
dv/buddy_block_allocator_tb.sv
